[design/grbf_pkg.sv]
// shared types, widths, codes and constant table of the gaussian rbf kernel row
// no dependencies
package grbf_pkg;

	localparam int DEF_MAX_CENTROIDS  = 16;
	localparam int DEF_MAX_DIMS       = 16;
	localparam int DEF_EXP_TABLE_BITS = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MODE_W     = 2;
	localparam int CNT_W      = 5;
	localparam int CI_W       = 4;
	localparam int DI_W       = 4;
	localparam int VAL_W      = 32;
	localparam int KV_W       = 17;
	localparam int ACC_W      = 48;
	localparam int GAIN_W     = 32;

	localparam logic [CNT_W-1:0]  RST_NUM_CENTROIDS = 5'd16;
	localparam logic [CNT_W-1:0]  RST_NUM_DIMS      = 5'd16;
	localparam logic [GAIN_W-1:0] RST_EXP_GAIN      = 32'd12102203;

	localparam logic [KV_W-1:0] KV_ONE = 17'd65536;

	// 2^-(2^-i) in Q0.32 for i = 1..12
	localparam int EXP_CONST_N = 12;
	localparam logic [31:0] EXP_CONSTS [EXP_CONST_N] = '{
		32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874793,
		32'd4202935003, 32'd4248701965, 32'd4271771997, 32'd4283353945,
		32'd4289156690, 32'd4292061010, 32'd4293513907, 32'd4294240540
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE          = 2'd0,
		REG_NUM_CENTROIDS = 2'd1,
		REG_NUM_DIMS      = 2'd2,
		REG_EXP_GAIN      = 2'd3
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_RAW    = 2'd0,
		MODE_DIST   = 2'd1,
		MODE_KERNEL = 2'd2
	} mode_t;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                    cmd;
		logic [CI_W-1:0]         centroid_index;
		logic [DI_W-1:0]         dim_index;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [CI_W-1:0] centroid_index_out;
		logic [KV_W-1:0] kernel_value;
		logic            last;
	} out_item_t;

endpackage

[design/grbf_chan_if.sv]
// valid/ready stream channel with a typed payload
// no dependencies; payload type is given at instantiation
interface grbf_chan_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/gaussian_rbf_kernel_row_top.sv]
// gaussian rbf kernel row: centroid store, distance accumulators, kernel output
// depends on grbf_pkg, grbf_chan_if, grbf_exp
//
//  channel   dir  payload                                        transfer when
//  in_ch     in   cmd, centroid_index, dim_index, value          valid && ready
//  out_ch    out  centroid_index_out, kernel_value, last         valid && ready
//  cfg       in   cfg_index, cfg_data                            cfg_wr_en
//
// one item at a time; ready is high only when the sequencer is idle
// mode 0 coordinate: one store and accumulator read per cycle, one per centroid
// emit (mode 0 last coordinate, mode 1): each result is computed by the iterative
// exponent unit, then registered for output; mode 2 goes straight to the output register
// accumulators read as zero after reset through per-entry flags, no clearing pass
// a stalled output holds the sequencer in its output state
module gaussian_rbf_kernel_row_top #(
	parameter int MAX_CENTROIDS  = grbf_pkg::DEF_MAX_CENTROIDS,
	parameter int MAX_DIMS       = grbf_pkg::DEF_MAX_DIMS,
	parameter int EXP_TABLE_BITS = grbf_pkg::DEF_EXP_TABLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [grbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grbf_pkg::CFG_DATA_W-1:0] cfg_data,
	grbf_chan_if.sink                       in_ch,
	grbf_chan_if.source                     out_ch
);
	import grbf_pkg::*;

	localparam int ACC_DEPTH   = (MAX_CENTROIDS < 16) ? MAX_CENTROIDS : 16;
	localparam int ACC_AW      = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int STORE_DEPTH = MAX_CENTROIDS * MAX_DIMS;
	localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] NC_CAP = CNT_W'(ACC_DEPTH);
	localparam logic [CNT_W-1:0] ND_CAP = CNT_W'((MAX_DIMS < 31) ? MAX_DIMS : 31);

	typedef enum logic [2:0] {
		S_IDLE, S_ACC, S_ACC_WAIT, S_E_RD, S_KS, S_KW, S_OUT
	} state_t;

	// configuration
	mode_t             mode_q;
	logic [CNT_W-1:0]  num_centroids_q;
	logic [CNT_W-1:0]  num_dims_q;
	logic [GAIN_W-1:0] exp_gain_q;
	logic [CNT_W-1:0]  eff_nc;
	logic [CNT_W-1:0]  eff_nd;

	// memories
	logic [VAL_W-1:0] store_mem [STORE_DEPTH];
	logic [ACC_W-1:0] acc_mem   [ACC_DEPTH];
	logic [ACC_DEPTH-1:0] acc_vld_q;

	// sequencer
	state_t            state_q;
	logic [ACC_AW-1:0] j_q;
	logic [DI_W-1:0]   di_q;
	logic [VAL_W-1:0]  val_q;
	logic              emit_q;
	logic              single_q;
	logic [CI_W-1:0]   tag_q;
	logic [KV_W-1:0]   kv_q;
	logic [ACC_W-1:0]  d_q;
	logic              out_vld_q;
	out_item_t         out_q;

	in_item_t          in_d;
	logic              in_fire;
	logic              j_last;
	logic              out_free;
	logic              store_we;
	logic [STORE_AW-1:0] store_waddr;
	logic [STORE_AW-1:0] store_raddr;

	// accumulate pipeline
	logic              v_s1, v_s2, v_s3;
	logic [ACC_AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [VAL_W-1:0]  store_rd_s1;
	logic [ACC_W-1:0]  acc_rd_s1;
	logic              acc_vld_s1;
	logic [31:0]       mag_s2;
	logic [ACC_W-1:0]  acc_s2;
	logic [63:0]       prod_s3;
	logic [ACC_W-1:0]  acc_s3;
	logic [32:0]       diff;
	logic [ACC_W:0]    sum_wide;
	logic [ACC_W-1:0]  acc_sum;

	// exponent unit
	logic              k_start;
	logic [ACC_W-1:0]  k_d;
	logic              k_done;
	logic [KV_W-1:0]   k_kv;

	assign in_d     = in_ch.data;
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire  = in_ch.valid && (state_q == S_IDLE);
	assign out_free = !out_vld_q || out_ch.ready;
	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = out_q;

	assign eff_nc = (num_centroids_q == '0) ? CNT_W'(1) :
		((num_centroids_q > NC_CAP) ? NC_CAP : num_centroids_q);
	assign eff_nd = (num_dims_q == '0) ? CNT_W'(1) :
		((num_dims_q > ND_CAP) ? ND_CAP : num_dims_q);
	assign j_last = (CNT_W'(j_q) == eff_nc - CNT_W'(1));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_RAW;
			num_centroids_q <= RST_NUM_CENTROIDS;
			num_dims_q      <= RST_NUM_DIMS;
			exp_gain_q      <= RST_EXP_GAIN;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODE:          mode_q          <= mode_t'(cfg_data[MODE_W-1:0]);
				REG_NUM_CENTROIDS: num_centroids_q <= cfg_data[CNT_W-1:0];
				REG_NUM_DIMS:      num_dims_q      <= cfg_data[CNT_W-1:0];
				REG_EXP_GAIN:      exp_gain_q      <= cfg_data[GAIN_W-1:0];
				default:           mode_q          <= mode_q;
			endcase
		end
	end

	// centroid store
	assign store_we = in_fire && (cmd_t'(in_d.cmd) == CMD_LOAD)
		&& (32'(in_d.centroid_index) < MAX_CENTROIDS) && (32'(in_d.dim_index) < MAX_DIMS);
	assign store_waddr = STORE_AW'(32'(in_d.centroid_index) * 32'(MAX_DIMS)
		+ 32'(in_d.dim_index));
	assign store_raddr = STORE_AW'(32'(j_q) * 32'(MAX_DIMS) + 32'(di_q));

	always_ff @(posedge clk) begin
		if (store_we)
			store_mem[store_waddr] <= in_d.value;
		store_rd_s1 <= store_mem[store_raddr];
	end

	// accumulator memory, written back from the last stage
	always_ff @(posedge clk) begin
		if (v_s3)
			acc_mem[idx_s3] <= acc_sum;
		acc_rd_s1  <= acc_mem[j_q];
		acc_vld_s1 <= acc_vld_q[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
		end else begin
			if (v_s3)
				acc_vld_q[idx_s3] <= 1'b1;
			if (state_q == S_KS && !single_q)
				acc_vld_q[j_q] <= 1'b0;
		end
	end

	// squared difference and saturating add
	assign diff     = {val_q[VAL_W-1], val_q} - {store_rd_s1[VAL_W-1], store_rd_s1};
	assign sum_wide = {1'b0, acc_s3} + {1'b0, prod_s3[63:16]};
	assign acc_sum  = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_ACC);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= j_q;
		idx_s2  <= idx_s1;
		mag_s2  <= diff[32] ? 32'(-diff) : diff[31:0];
		acc_s2  <= acc_vld_s1 ? acc_rd_s1 : '0;
		idx_s3  <= idx_s2;
		prod_s3 <= 64'(mag_s2) * 64'(mag_s2);
		acc_s3  <= acc_s2;
	end

	// exponent
	assign k_start = (state_q == S_KS);
	assign k_d     = single_q ? d_q : (acc_vld_s1 ? acc_rd_s1 : '0);

	grbf_exp #(
		.EXP_TABLE_BITS(EXP_TABLE_BITS)
	) u_exp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (k_start),
		.d     (k_d),
		.gain  (exp_gain_q),
		.done  (k_done),
		.kv    (k_kv)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			j_q       <= '0;
			di_q      <= '0;
			val_q     <= '0;
			emit_q    <= 1'b0;
			single_q  <= 1'b0;
			tag_q     <= '0;
			kv_q      <= '0;
			d_q       <= '0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (out_ch.ready && state_q != S_OUT)
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire && cmd_t'(in_d.cmd) == CMD_SAMPLE) begin
						case (mode_q)
							MODE_RAW: begin
								if (CNT_W'(in_d.dim_index) < eff_nd) begin
									di_q    <= in_d.dim_index;
									val_q   <= in_d.value;
									emit_q  <= (CNT_W'(in_d.dim_index) == eff_nd - CNT_W'(1));
									j_q     <= '0;
									state_q <= S_ACC;
								end
							end
							MODE_DIST: begin
								d_q      <= in_d.value[VAL_W-1] ? '0 : ACC_W'(in_d.value[VAL_W-2:0]);
								tag_q    <= in_d.centroid_index;
								single_q <= 1'b1;
								state_q  <= S_KS;
							end
							MODE_KERNEL: begin
								if (in_d.value[VAL_W-1])
									kv_q <= '0;
								else if (in_d.value > 32'sd65536)
									kv_q <= KV_ONE;
								else
									kv_q <= in_d.value[KV_W-1:0];
								tag_q    <= in_d.centroid_index;
								single_q <= 1'b1;
								state_q  <= S_OUT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ACC: begin
					if (j_last) begin
						j_q     <= '0;
						state_q <= S_ACC_WAIT;
					end else begin
						j_q <= j_q + ACC_AW'(1);
					end
				end
				S_ACC_WAIT: begin
					if (!(v_s1 || v_s2 || v_s3)) begin
						single_q <= 1'b0;
						state_q  <= emit_q ? S_E_RD : S_IDLE;
					end
				end
				S_E_RD: state_q <= S_KS;
				S_KS:   state_q <= S_KW;
				S_KW: begin
					if (k_done) begin
						kv_q    <= k_kv;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						out_q.centroid_index_out <= single_q ? tag_q : CI_W'(j_q);
						out_q.kernel_value       <= kv_q;
						out_q.last               <= single_q || j_last;
						if (single_q || j_last) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + ACC_AW'(1);
							state_q <= S_E_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[design/grbf_exp.sv]
// iterative 2^-(d*gain) unit: two partial products, then one table multiply per step
// depends on grbf_pkg
module grbf_exp #(
	parameter int EXP_TABLE_BITS = grbf_pkg::DEF_EXP_TABLE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [grbf_pkg::ACC_W-1:0]  d,
	input  logic [grbf_pkg::GAIN_W-1:0] gain,
	output logic                        done,
	output logic [grbf_pkg::KV_W-1:0]   kv
);
	import grbf_pkg::*;

	localparam int STEPS  = (EXP_TABLE_BITS < EXP_CONST_N) ? EXP_TABLE_BITS : EXP_CONST_N;
	localparam int STEP_W = $clog2(EXP_CONST_N);

	typedef enum logic [1:0] {K_IDLE, K_SUM, K_ITER, K_FIN} kstate_t;

	kstate_t           state_q;
	logic [55:0]       pa_q;
	logic [55:0]       pb_q;
	logic [56:0]       t_sum;
	logic              zero_q;
	logic [4:0]        n_q;
	logic [15:0]       f_q;
	logic [32:0]       a_q;
	logic [64:0]       a_prod;
	logic [32:0]       a_next;
	logic [STEP_W-1:0] step_q;
	logic [5:0]        rnd_sh;
	logic [5:0]        out_sh;
	logic [33:0]       a_rnd;
	logic              done_q;
	logic [KV_W-1:0]   kv_q;

	assign t_sum  = {1'b0, pa_q} + 57'(pb_q >> 24);
	assign a_prod = 65'(a_q) * 65'(EXP_CONSTS[step_q]);
	assign a_next = 33'((a_prod + (65'd1 << 31)) >> 32);
	assign rnd_sh = 6'(n_q) + 6'd15;
	assign out_sh = 6'(n_q) + 6'd16;
	assign a_rnd  = 34'(a_q) + (34'd1 << rnd_sh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= K_IDLE;
			done_q  <= 1'b0;
			kv_q    <= '0;
			pa_q    <= '0;
			pb_q    <= '0;
			zero_q  <= 1'b0;
			n_q     <= '0;
			f_q     <= '0;
			a_q     <= '0;
			step_q  <= '0;
		end else begin
			done_q <= (state_q == K_FIN);
			case (state_q)
				K_IDLE: begin
					if (start) begin
						pa_q    <= 56'(d[47:24]) * 56'(gain);
						pb_q    <= 56'(d[23:0]) * 56'(gain);
						state_q <= K_SUM;
					end
				end
				K_SUM: begin
					zero_q  <= (t_sum[56:16] >= 41'd17);
					n_q     <= t_sum[20:16];
					f_q     <= t_sum[15:0];
					a_q     <= 33'd1 << 32;
					step_q  <= '0;
					state_q <= K_ITER;
				end
				K_ITER: begin
					if (f_q[4'(4'd15 - 4'(step_q))])
						a_q <= a_next;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(STEPS - 1))
						state_q <= K_FIN;
				end
				K_FIN: begin
					kv_q    <= zero_q ? '0 : KV_W'(a_rnd >> out_sh);
					state_q <= K_IDLE;
				end
				default: state_q <= K_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign kv   = kv_q;

endmodule
